// ===== rtl/integer_to_ascii_radix_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix integer-to-ASCII converter
// Concurrent checks that share one clock and one active-low reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITOAR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("itoar check failed");

// The consequent must hold in the cycle after the antecedent.
`define ITOAR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("itoar check failed");

`endif

// ===== rtl/itoar_pkg.sv =====
// ----------------------------------------------------------------------------
// itoar_pkg
// Shared widths, character codes and helpers of the radix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itoar_pkg;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 5;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] MIN_RADIX     = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX     = 6'd32;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;

  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

  // Status of the shared divider: a one-cycle done strobe and the remainder.
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_stat_t;

  // Maps a digit value to '0'..'9' or 'A' onward.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d >= DECIMAL_DIGITS) begin
      return CHAR_LETTER + dx - {{(CHAR_W-DIGIT_W){1'b0}}, DECIMAL_DIGITS};
    end
    return CHAR_ZERO + dx;
  endfunction

endpackage

// ===== rtl/itoar_divider.sv =====
// ----------------------------------------------------------------------------
// itoar_divider
// Iterative unsigned divider of a WIDTH-bit magnitude by a small radix,
// four quotient bits per cycle by restoring compare and subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoar_divider #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [WIDTH-1:0]              dividend_i,
  input  logic [itoar_pkg::RADIX_W-1:0] divisor_i,
  output logic [WIDTH-1:0]              quotient_o,
  output itoar_pkg::div_stat_t          stat_o
);

  localparam int unsigned QBITS = 4;
  localparam int unsigned STEPS = (WIDTH + QBITS - 1) / QBITS;
  localparam int unsigned PW    = STEPS * QBITS;
  localparam int unsigned SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned DW    = itoar_pkg::DIGIT_W;
  localparam int unsigned RW    = itoar_pkg::RADIX_W;

  logic [PW-1:0]  work_q, work_d;
  logic [DW-1:0]  rem_q, rem_d;
  logic [RW-1:0]  divisor_q;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;

  // Four dependent compare-subtract steps on a remainder below 32.
  always_comb begin
    logic [DW-1:0]    r;
    logic [RW-1:0]    t;
    logic [QBITS-1:0] q;
    r = rem_q;
    q = '0;
    for (int j = 0; j < QBITS; j++) begin
      t = {r, work_q[PW-1-j]};
      if (t >= divisor_q) begin
        t = t - divisor_q;
        q[QBITS-1-j] = 1'b1;
      end
      r = t[DW-1:0];
    end

    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = PW'(dividend_i);
      rem_d  = '0;
      cnt_d  = SCW'(STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = {work_q[PW-QBITS-1:0], q};
      rem_d  = r;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign quotient_o  = work_q[WIDTH-1:0];
  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

// ===== rtl/itoar_digit_store.sv =====
// ----------------------------------------------------------------------------
// itoar_digit_store
// Digit memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoar_digit_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [itoar_pkg::DIGIT_W-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [itoar_pkg::DIGIT_W-1:0] rdata_o
);

  logic [itoar_pkg::DIGIT_W-1:0] mem_q [DEPTH];
  logic [itoar_pkg::DIGIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a signed number to ASCII digits in a base from 2 to 32.
// ----------------------------------------------------------------------------
// The block takes one word holding a two's complement value and a base, and
// returns its magnitude as one ASCII character per output word, most
// significant digit first, with tlast on the final character. Digit values
// 0 to 9 become '0' to '9' and 10 to 31 become 'A' to 'V'. A '-' leads only
// for a negative value in base 10. A base outside 2..32 gives one word with
// character zero, tlast set and tuser (invalid) set. Only the low VALUE_WIDTH
// bits of the value are used; the most negative value converts as
// 2^(VALUE_WIDTH-1). Rate: one conversion at a time. Each digit costs one
// pass of the shared divider, which retires four quotient bits per cycle;
// each character then takes a digit memory read and then a load of the
// output register, which waits while that register is full and not taken.
// The output register lets a new input word be accepted while the last
// character still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integer_to_ascii_radix_assert.svh"

module integer_to_ascii_radix #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // [63:0] value, [69:64] radix, rest zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] ascii_char
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o   // [0] invalid
);

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned RW = itoar_pkg::RADIX_W;
  localparam int unsigned DW = itoar_pkg::DIGIT_W;
  localparam int unsigned KW = itoar_pkg::CHAR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_BAD  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          minus_q, minus_d;
  logic [RW-1:0] radix_q, radix_d;
  logic          out_valid_q, out_valid_d;
  logic [KW-1:0] out_char_q, out_char_d;
  logic          out_last_q, out_last_d;
  logic          out_inv_q, out_inv_d;

  logic [VALUE_WIDTH-1:0] in_value;
  logic [RW-1:0]          in_radix;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic                   in_neg;
  logic                   in_accept;
  logic                   out_free;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RW-1:0]          div_divisor;
  logic [VALUE_WIDTH-1:0] div_quotient;
  itoar_pkg::div_stat_t   div_stat;

  logic          mem_we;
  logic          mem_re;
  logic [DW-1:0] mem_rdata;

  assign in_value  = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_radix  = s_axis_tdata_i[64 +: RW];
  assign in_neg    = in_value[VALUE_WIDTH-1];
  // Plain negation: the most negative value wraps onto 2^(VALUE_WIDTH-1),
  // which is exactly its magnitude when read as unsigned.
  assign in_mag    = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  // The output register may be loaded when it is empty or being emptied.
  assign out_free        = ~out_valid_q | m_axis_tready_i;

  itoar_divider #(
    .WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .stat_o     (div_stat)
  );

  // Digits land least significant first at the running count and are read
  // back from the top index down.
  itoar_digit_store #(
    .DEPTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (div_stat.rem),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    minus_d      = minus_q;
    radix_d      = radix_q;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_inv_d    = out_inv_q;
    div_start    = 1'b0;
    div_dividend = in_mag;
    div_divisor  = in_radix;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if ((in_radix < itoar_pkg::MIN_RADIX) || (in_radix > itoar_pkg::MAX_RADIX)) begin
            state_d = S_BAD;
          end else begin
            div_start = 1'b1;
            count_d   = '0;
            radix_d   = in_radix;
            minus_d   = in_neg && (in_radix == itoar_pkg::RADIX_DECIMAL);
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        // The input bus may already carry the next word, so later passes
        // divide by the base held since acceptance.
        div_dividend = div_quotient;
        div_divisor  = radix_q;
        if (div_stat.done) begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          if (div_quotient == '0) begin
            // The digit just written is the most significant one.
            idx_d   = count_q[AW-1:0];
            state_d = minus_q ? S_SIGN : S_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoar_pkg::CHAR_MINUS;
          out_last_d  = 1'b0;
          out_inv_d   = 1'b0;
          minus_d     = 1'b0;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoar_pkg::digit_to_ascii(mem_rdata);
          out_last_d  = (idx_q == '0);
          out_inv_d   = 1'b0;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_BAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoar_pkg::CHAR_NONE;
          out_last_d  = 1'b1;
          out_inv_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      minus_q     <= minus_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_inv_q  <= out_inv_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_inv_q;

  // The divider finishes only while the sequencer waits for it.
  `ITOAR_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_stat.done, state_q == S_DIV)
  // Every digit read back was written earlier in the same conversion.
  `ITOAR_ASSERT_IMP(a_read_written, clk_i, rst_ni, mem_re, CW'(idx_q) < count_q)
  // An invalid word is a lone, final, zero character.
  `ITOAR_ASSERT_IMP(a_invalid_word, clk_i, rst_ni, out_valid_q && out_inv_q,
                    out_last_q && (out_char_q == itoar_pkg::CHAR_NONE))
  // An accepted word always leaves the idle state.
  `ITOAR_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_accept, state_q != S_IDLE)

endmodule

// ===== bench/tb_integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix
// Self-checking bench for the radix integer-to-ASCII converter.
// ----------------------------------------------------------------------------
// A driver feeds conversion requests (value and base) from a queue that the
// stimulus block fills: a directed set of corner cases first, then random
// requests. Each accepted input word is run through a behavioral predictor,
// and the characters it should produce are queued. A monitor takes every
// output word and compares character, tlast and the invalid flag with the
// oldest queued character. Both sides stall at random, with one long
// stretch where neither side stalls, and the sender drains the block
// completely at least once before it continues.
// ----------------------------------------------------------------------------

module tb_integer_to_ascii_radix;

  localparam int unsigned RADIX_W = itoar_pkg::RADIX_W;
  localparam int unsigned DIGIT_W = itoar_pkg::DIGIT_W;
  localparam int unsigned CHAR_W  = itoar_pkg::CHAR_W;

  // Chance in percent that a side idles in a given cycle.
  localparam int unsigned STALL_PCT = 31;
  localparam int unsigned RANDOM_WORDS = 288;
  // The final quiet period and the watchdog are both sized well above the
  // length of a base-2 conversion of a full 64-bit magnitude.
  localparam int unsigned DRAIN_CYCLES = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // Input words in this range are sent and taken with no idling at all.
  localparam int unsigned STEADY_FROM = 120;
  localparam int unsigned STEADY_TO = 180;

  typedef struct {
    logic [63:0]        value;
    logic [RADIX_W-1:0] radix;
    bit                 drain_first;  // wait for every pending character first
  } conv_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
    logic              invalid;
  } char_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  conv_req_t   req_q[$];       // requests not yet put on the bus
  char_word_t  char_q[$];      // characters predicted but not yet seen
  conv_req_t   req_on_bus;
  char_word_t  want_char;
  int unsigned words_in = 0;
  int unsigned req_total = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;

  wire steady = (words_in >= STEADY_FROM) && (words_in < STEADY_TO);

  integer_to_ascii_radix DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // [63:0] value, [69:64] radix, rest zero
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),   // [7:0] ascii_char
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)    // [0] invalid
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Works out the characters of one conversion and queues them in order.
  // The magnitude is taken in 64-bit unsigned arithmetic, so the most
  // negative value comes out as 2^63 without any overflow.
  function automatic void predict_chars(input conv_req_t req);
    logic [63:0]        mag;
    logic [63:0]        base;
    logic [DIGIT_W-1:0] digs[64];
    int                 n;
    char_word_t         w;
    if (req.radix < itoar_pkg::MIN_RADIX || req.radix > itoar_pkg::MAX_RADIX) begin
      w.ascii_char = itoar_pkg::CHAR_NONE;
      w.last = 1'b1;
      w.invalid = 1'b1;
      char_q.push_back(w);
      return;
    end
    base = 64'(req.radix);
    mag = req.value[63] ? (~req.value + 64'd1) : req.value;
    n = 0;
    // Digits are collected least significant first; zero still yields one.
    do begin
      digs[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0);
    w.invalid = 1'b0;
    // The sign only shows in decimal, and zero is never negative.
    if (req.value[63] && req.radix == itoar_pkg::RADIX_DECIMAL) begin
      w.ascii_char = itoar_pkg::CHAR_MINUS;
      w.last = 1'b0;
      char_q.push_back(w);
    end
    for (int i = n - 1; i >= 0; i--) begin
      if (digs[i] < itoar_pkg::DECIMAL_DIGITS) begin
        w.ascii_char = itoar_pkg::CHAR_ZERO + CHAR_W'(digs[i]);
      end else begin
        w.ascii_char = itoar_pkg::CHAR_LETTER + CHAR_W'(digs[i])
                       - CHAR_W'(itoar_pkg::DECIMAL_DIGITS);
      end
      w.last = (i == 0);
      char_q.push_back(w);
    end
  endfunction

  function automatic void add_req(input logic [63:0] value, input logic [RADIX_W-1:0] radix,
                                  input bit drain_first);
    conv_req_t r;
    r.value = value;
    r.radix = radix;
    r.drain_first = drain_first;
    req_q.push_back(r);
    req_total++;
  endfunction

  // Driver. A word that was accepted at this edge is predicted first; then,
  // if the bus slot is free, the next request goes out unless this cycle is
  // an idle one or the request asks for the block to be drained first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_chars(req_on_bus);
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 && (steady || $urandom_range(0, 99) >= STALL_PCT) &&
            !(req_q[0].drain_first && char_q.size() != 0)) begin
          req_on_bus = req_q.pop_front();
          s_axis_tdata <= {2'b00, req_on_bus.radix, req_on_bus.value};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every output word must match the oldest predicted character.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (char_q.size() == 0) begin
          $error("unexpected word: ascii_char %h last %b invalid %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          fail_cnt++;
        end else begin
          want_char = char_q.pop_front();
          if (m_axis_tdata !== want_char.ascii_char) begin
            $error("ascii_char: expected %h, actual %h", want_char.ascii_char, m_axis_tdata);
            fail_cnt++;
          end
          if (m_axis_tlast !== want_char.last) begin
            $error("last: expected %b, actual %b", want_char.last, m_axis_tlast);
            fail_cnt++;
          end
          if (m_axis_tuser !== want_char.invalid) begin
            $error("invalid: expected %b, actual %b", want_char.invalid, m_axis_tuser);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL integer_to_ascii_radix");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] v;
    logic [31:0] w32;
    int unsigned pick;
    logic [RADIX_W-1:0] r;

    // Directed corner cases: zero, the most negative and most positive
    // values, letters at the top of the digit range, and bad bases.
    add_req(64'd0, itoar_pkg::RADIX_DECIMAL, 1'b0);
    add_req(64'd0, itoar_pkg::MIN_RADIX, 1'b0);
    add_req(64'h8000_0000_0000_0000, itoar_pkg::MIN_RADIX, 1'b0);
    add_req(64'h8000_0000_0000_0000, itoar_pkg::RADIX_DECIMAL, 1'b0);
    add_req(64'h8000_0000_0000_0000, 6'd16, 1'b0);
    add_req(64'h8000_0000_0000_0000, itoar_pkg::MAX_RADIX, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, itoar_pkg::MIN_RADIX, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, itoar_pkg::RADIX_DECIMAL, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, itoar_pkg::MAX_RADIX, 1'b0);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, itoar_pkg::RADIX_DECIMAL, 1'b0);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 1'b0);
    add_req(64'd31, itoar_pkg::MAX_RADIX, 1'b0);
    add_req(64'd10, 6'd11, 1'b0);
    add_req(-64'd255, itoar_pkg::RADIX_DECIMAL, 1'b0);
    add_req(-64'd255, 6'd16, 1'b0);
    add_req(64'd1000, 6'd7, 1'b0);
    add_req(64'd1, 6'd3, 1'b0);
    add_req({$urandom, $urandom}, 6'd0, 1'b0);
    add_req({$urandom, $urandom}, 6'd1, 1'b0);
    add_req({$urandom, $urandom}, 6'd33, 1'b0);
    add_req({$urandom, $urandom}, 6'd63, 1'b1);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, itoar_pkg::MIN_RADIX, 1'b0);

    // Random part: mostly valid bases with a mix of value shapes, some
    // extra weight on decimal for the sign, and a share of bad bases.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(0, 9);
      w32 = $urandom;
      case (pick) inside
        4, 5:    v = 64'($urandom_range(0, 1000));
        6, 7:    v = -64'($urandom_range(1, 1000));
        8:       v = {{32{w32[31]}}, w32};
        9:       v = $urandom_range(0, 1) ? {1'b1, 31'd0, w32} : {1'b0, {31{1'b1}}, w32};
        default: v = {$urandom, w32};
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(33, 63))
                                 : RADIX_W'($urandom_range(0, 1));
      end else if (pick < 25) begin
        r = itoar_pkg::RADIX_DECIMAL;
      end else begin
        r = RADIX_W'($urandom_range(itoar_pkg::MIN_RADIX, itoar_pkg::MAX_RADIX));
      end
      add_req(v, r, k == RANDOM_WORDS / 2);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every character to come back,
    // then give the block time to show any stray output.
    while (words_in != req_total || char_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("PASS integer_to_ascii_radix");
    end else begin
      $display("FAIL integer_to_ascii_radix");
    end
    $finish;
  end

endmodule
